>>> hw/rtl/alte_pkg.sv
// Shared types and constants for the array list table engine.
package alte_pkg;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 10;
    localparam int IDX_W  = 11;
    localparam int STAT_W = 3;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_REPLACE = 3'd1,
        OP_DELETE  = 3'd2,
        OP_FIND    = 3'd3,
        OP_INSERT  = 3'd4,
        OP_MAX     = 3'd5,
        OP_READ    = 3'd6
    } t_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_BAD_POS   = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_READ
    } t_state;

    // Read address source
    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_M1,
        RD_POS
    } t_rd_sel;

    // Write address and data source
    typedef enum logic [2:0] {
        WR_TAIL,
        WR_MATCH,
        WR_DN,
        WR_UP,
        WR_POS
    } t_wr_sel;

    // Walk pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_MATCH_P1,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    // Entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Result index source
    typedef enum logic [2:0] {
        IDX_NONE,
        IDX_NEW_COUNT,
        IDX_RD,
        IDX_MATCH,
        IDX_POS
    } t_idx_sel;

    // Result data source
    typedef enum logic [1:0] {
        DAT_NONE,
        DAT_MAX,
        DAT_RD
    } t_dat_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_ptr_op  ptr_op;
        t_cnt_op  cnt_op;
        logic     save_match;
        logic     max_en;
        logic     finish;
        t_status  status;
        t_idx_sel idx_sel;
        t_dat_sel dat_sel;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_bad;
        logic match;
        logic rd_vld;
        logic scan_more;
        logic up_more;
    } t_stat;

endpackage

>>> hw/rtl/array_list_table_engine.sv
// Top level of the array list table engine.
//
// Keeps a packed list of up to DEPTH signed 32-bit entries and a count.
// Command channel: drive i_command, i_value, i_new_value and i_position
// with start high; the item is taken at a rising edge where busy is low.
// Result channel: o_done pulses for one cycle with o_status, o_index,
// o_data and o_count; there is no back pressure, so the result must be
// taken in that cycle.
// Append, error results and unused codes finish without a walk; read_at
// reads one entry; find/replace walk up to the first match or the end;
// delete walks to the first match and moves every later entry down; max
// walks every entry; insert_at moves entries up from the tail down to the
// position and then writes the value there.
// The walk is set by the single entry memory: one read and one write per
// cycle, read data registered. busy stays high while an item is worked;
// a new item may be started in the cycle o_done is shown.
// Reset (i_rst_n low, synchronous) empties the list; entry contents are
// not cleared and only entries below the count are ever read.
module array_list_table_engine
    import alte_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic        [CMD_W-1:0]  i_command,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic signed [VAL_W-1:0]  i_new_value,
    input  logic        [POS_W-1:0]  i_position,
    output logic                     o_done,
    output logic        [STAT_W-1:0] o_status,
    output logic        [IDX_W-1:0]  o_index,
    output logic signed [VAL_W-1:0]  o_data,
    output logic        [IDX_W-1:0]  o_count
);

    t_ctl  ctl;
    t_stat stat;

    // Sequencer
    alte_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (stat),
        .o_busy    (busy),
        .o_ctl     (ctl)
    );

    // Storage and result path
    alte_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_new_value (i_new_value),
        .i_position  (i_position),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_index     (o_index),
        .o_data      (o_data),
        .o_count     (o_count)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A result is shown only after the sequencer has returned to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // Error results carry zero index and data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |-> ((o_index == '0) && (o_data == '0)))
        else $error("error result with nonzero index or data");

    // Memory is never written and read in the walk without an item in work
    a_mem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.wr_en || ctl.rd_en) |-> busy)
        else $error("memory access while idle");
`endif

endmodule

>>> hw/rtl/alte_ctrl.sv
// Command sequencer for the array list table engine.
module alte_ctrl
    import alte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMD_W-1:0] i_command,
    input  t_stat            i_stat,
    output logic             o_busy,
    output t_ctl             o_ctl
);

    t_state           r_state;
    t_state           n_state;
    logic [CMD_W-1:0] r_op;

    logic             walk_done;
    logic             up_done;

    assign walk_done = !i_stat.scan_more && !i_stat.rd_vld;
    assign up_done   = !i_stat.up_more && !i_stat.rd_vld;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the command of the accepted item
    always_ff @(posedge i_clk) begin
        if (o_ctl.load) begin
            r_op <= i_command;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_op) inside
                    OP_REPLACE, OP_DELETE, OP_FIND, OP_MAX: begin
                        n_state = i_stat.empty ? S_IDLE : S_SCAN;
                    end
                    OP_INSERT: begin
                        n_state = (i_stat.full || i_stat.pos_bad) ? S_IDLE : S_SHIFT_UP;
                    end
                    OP_READ: begin
                        n_state = i_stat.pos_bad ? S_IDLE : S_READ;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_op == OP_MAX) begin
                    if (walk_done) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.match) begin
                    n_state = (r_op == OP_DELETE) ? S_SHIFT_DN : S_IDLE;
                end else if (walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_DN: begin
                if (walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_UP: begin
                if (up_done) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_busy           = (r_state != S_IDLE);
        o_ctl.load       = 1'b0;
        o_ctl.rd_en      = 1'b0;
        o_ctl.rd_sel     = RD_PTR;
        o_ctl.wr_en      = 1'b0;
        o_ctl.wr_sel     = WR_TAIL;
        o_ctl.ptr_op     = PTR_HOLD;
        o_ctl.cnt_op     = CNT_HOLD;
        o_ctl.save_match = 1'b0;
        o_ctl.max_en     = 1'b0;
        o_ctl.finish     = 1'b0;
        o_ctl.status     = STAT_OK;
        o_ctl.idx_sel    = IDX_NONE;
        o_ctl.dat_sel    = DAT_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_start;
            end
            S_DECODE: begin
                unique case (r_op) inside
                    OP_APPEND: begin
                        o_ctl.finish = 1'b1;
                        if (i_stat.full) begin
                            o_ctl.status = STAT_FULL;
                        end else begin
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.wr_sel  = WR_TAIL;
                            o_ctl.cnt_op  = CNT_INC;
                            o_ctl.idx_sel = IDX_NEW_COUNT;
                        end
                    end
                    OP_REPLACE, OP_DELETE, OP_FIND: begin
                        if (i_stat.empty) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = STAT_NOT_FOUND;
                        end else begin
                            o_ctl.ptr_op = PTR_ZERO;
                        end
                    end
                    OP_MAX: begin
                        if (i_stat.empty) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = STAT_EMPTY;
                        end else begin
                            o_ctl.ptr_op = PTR_ZERO;
                        end
                    end
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = STAT_FULL;
                        end else if (i_stat.pos_bad) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = STAT_BAD_POS;
                        end else begin
                            o_ctl.ptr_op = PTR_COUNT;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.pos_bad) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = STAT_BAD_POS;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RD_POS;
                        end
                    end
                    default: begin
                        o_ctl.finish = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_op == OP_MAX) begin
                    // Walk every entry, keep the running maximum
                    o_ctl.max_en = 1'b1;
                    if (i_stat.scan_more) begin
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.ptr_op = PTR_INC;
                    end
                    if (walk_done) begin
                        o_ctl.finish  = 1'b1;
                        o_ctl.dat_sel = DAT_MAX;
                    end
                end else if (i_stat.match) begin
                    // Stop at the first match
                    if (r_op == OP_DELETE) begin
                        o_ctl.save_match = 1'b1;
                        o_ctl.ptr_op     = PTR_MATCH_P1;
                    end else begin
                        o_ctl.finish  = 1'b1;
                        o_ctl.idx_sel = IDX_RD;
                        if (r_op == OP_REPLACE) begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = WR_MATCH;
                        end
                    end
                end else if (i_stat.scan_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.ptr_op = PTR_INC;
                end else if (!i_stat.rd_vld) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.status = STAT_NOT_FOUND;
                end
            end
            S_SHIFT_DN: begin
                // Move each later entry down by one
                if (i_stat.rd_vld) begin
                    o_ctl.wr_en  = 1'b1;
                    o_ctl.wr_sel = WR_DN;
                end
                if (i_stat.scan_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.ptr_op = PTR_INC;
                end
                if (walk_done) begin
                    o_ctl.finish  = 1'b1;
                    o_ctl.cnt_op  = CNT_DEC;
                    o_ctl.idx_sel = IDX_MATCH;
                end
            end
            S_SHIFT_UP: begin
                // Move entries up by one from the tail, then drop the value in
                if (i_stat.rd_vld) begin
                    o_ctl.wr_en  = 1'b1;
                    o_ctl.wr_sel = WR_UP;
                end
                if (i_stat.up_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_PTR_M1;
                    o_ctl.ptr_op = PTR_DEC;
                end
                if (up_done) begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.wr_sel  = WR_POS;
                    o_ctl.cnt_op  = CNT_INC;
                    o_ctl.finish  = 1'b1;
                    o_ctl.idx_sel = IDX_POS;
                end
            end
            S_READ: begin
                o_ctl.finish  = 1'b1;
                o_ctl.idx_sel = IDX_POS;
                o_ctl.dat_sel = DAT_RD;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/alte_dp.sv
// Entry memory, count, walk pointer and result registers.
module alte_dp
    import alte_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic signed [VAL_W-1:0]  i_new_value,
    input  logic        [POS_W-1:0]  i_position,
    input  t_ctl                     i_ctl,
    output t_stat                    o_stat,
    output logic                     o_done,
    output logic        [STAT_W-1:0] o_status,
    output logic        [IDX_W-1:0]  o_index,
    output logic signed [VAL_W-1:0]  o_data,
    output logic        [IDX_W-1:0]  o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic        [VAL_W-1:0] mem [DEPTH];

    logic        [CW-1:0]    r_count;
    logic        [CW-1:0]    n_count;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] r_new_value;
    logic        [POS_W-1:0] r_pos;
    logic        [CW-1:0]    r_ptr;
    logic        [CW-1:0]    n_ptr;
    logic                    r_rd_vld;
    logic        [CW-1:0]    r_rd_idx;
    logic signed [VAL_W-1:0] r_rd_data;
    logic signed [VAL_W-1:0] r_max;
    logic        [CW-1:0]    r_match;
    logic                    r_done;
    t_status                 r_status;
    logic        [IDX_W-1:0] r_index;
    logic signed [VAL_W-1:0] r_data;
    logic        [IDX_W-1:0] r_out_count;

    logic        [XW-1:0]    pos_x;
    logic        [XW-1:0]    cnt_x;
    logic        [CW-1:0]    pos_c;
    logic        [CW-1:0]    rd_idx;
    logic        [CW-1:0]    wr_idx;
    logic        [VAL_W-1:0] wr_data;
    logic        [CW-1:0]    idx_val;
    logic signed [VAL_W-1:0] dat_val;

    // Position and count at a common width
    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign pos_c = pos_x[CW-1:0];

    // Status to the controller
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.pos_bad   = (pos_x >= cnt_x);
    assign o_stat.match     = r_rd_vld && (r_rd_data == r_value);
    assign o_stat.rd_vld    = r_rd_vld;
    assign o_stat.scan_more = (r_ptr < r_count);
    assign o_stat.up_more   = (XW'(r_ptr) > pos_x);

    // Select read index
    always_comb begin
        case (i_ctl.rd_sel)
            RD_PTR:    rd_idx = r_ptr;
            RD_PTR_M1: rd_idx = r_ptr - 1'b1;
            RD_POS:    rd_idx = pos_c;
            default:   rd_idx = r_ptr;
        endcase
    end

    // Select write index and data
    always_comb begin
        case (i_ctl.wr_sel)
            WR_TAIL: begin
                wr_idx  = r_count;
                wr_data = r_value;
            end
            WR_MATCH: begin
                wr_idx  = r_rd_idx;
                wr_data = r_new_value;
            end
            WR_DN: begin
                wr_idx  = r_rd_idx - 1'b1;
                wr_data = r_rd_data;
            end
            WR_UP: begin
                wr_idx  = r_rd_idx + 1'b1;
                wr_data = r_rd_data;
            end
            WR_POS: begin
                wr_idx  = pos_c;
                wr_data = r_value;
            end
            default: begin
                wr_idx  = r_count;
                wr_data = r_value;
            end
        endcase
    end

    // Next count
    always_comb begin
        case (i_ctl.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Next walk pointer
    always_comb begin
        case (i_ctl.ptr_op)
            PTR_ZERO:     n_ptr = '0;
            PTR_COUNT:    n_ptr = r_count;
            PTR_MATCH_P1: n_ptr = r_rd_idx + 1'b1;
            PTR_INC:      n_ptr = r_ptr + 1'b1;
            PTR_DEC:      n_ptr = r_ptr - 1'b1;
            default:      n_ptr = r_ptr;
        endcase
    end

    // Result index and data
    always_comb begin
        case (i_ctl.idx_sel)
            IDX_NEW_COUNT: idx_val = n_count;
            IDX_RD:        idx_val = r_rd_idx;
            IDX_MATCH:     idx_val = r_match;
            IDX_POS:       idx_val = pos_c;
            default:       idx_val = '0;
        endcase
        case (i_ctl.dat_sel)
            DAT_MAX: dat_val = r_max;
            DAT_RD:  dat_val = r_rd_data;
            default: dat_val = '0;
        endcase
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[rd_idx[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_ctl.rd_en;
            r_done   <= i_ctl.finish;
        end
    end

    // Latch operands, advance pointer, track match and maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value     <= i_value;
            r_new_value <= i_new_value;
            r_pos       <= i_position;
        end
        r_ptr <= n_ptr;
        if (i_ctl.rd_en) begin
            r_rd_idx <= rd_idx;
        end
        if (i_ctl.save_match) begin
            r_match <= r_rd_idx;
        end
        if (i_ctl.max_en && r_rd_vld) begin
            if ((r_rd_idx == '0) || (r_rd_data > r_max)) begin
                r_max <= r_rd_data;
            end
        end
    end

    // Capture the result item
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status    <= i_ctl.status;
            r_index     <= IDX_W'(idx_val);
            r_data      <= dat_val;
            r_out_count <= IDX_W'(n_count);
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_index  = r_index;
    assign o_data   = r_data;
    assign o_count  = r_out_count;

endmodule

>>> dv/array_list_table_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the array list table engine.
module array_list_table_engine_tb
    import alte_pkg::*;
();

    localparam int LIST_DEPTH  = 1024;
    localparam int STALL_LIMIT = 8000;
    localparam int LONG_LEN    = 80;

    // Code outside the command set; the block must leave the list alone
    localparam logic [CMD_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        t_status                 status;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] data;
        logic [IDX_W-1:0]        count;
    } t_list_result;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] nval;
        logic [POS_W-1:0]        pos;
        bit                      typed;
        t_list_result            res;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic        [CMD_W-1:0]  i_command = '0;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic signed [VAL_W-1:0]  i_new_value = '0;
    logic        [POS_W-1:0]  i_position = '0;
    logic                     o_done;
    logic        [STAT_W-1:0] o_status;
    logic        [IDX_W-1:0]  o_index;
    logic signed [VAL_W-1:0]  o_data;
    logic        [IDX_W-1:0]  o_count;

    // Shadow copy of the list kept by the predictor
    logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
    int                      shadow_len = 0;

    t_list_result pending_results[$];
    t_stim_row    directed_rows[$];
    t_list_result blank_res;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    bit           burst_mode = 1'b0;

    array_list_table_engine #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_new_value(i_new_value),
        .i_position (i_position),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_index    (o_index),
        .o_data     (o_data),
        .o_count    (o_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string field, input logic [VAL_W-1:0] got_val,
                                   input logic [VAL_W-1:0] want_val);
        $display("[%0t] %s mismatch: got %0h, expected %0h", $time, field, got_val, want_val);
        mismatch_count++;
    endtask

    function automatic t_list_result make_result(input t_status st, input int idx,
                                                 input logic signed [VAL_W-1:0] dat,
                                                 input int cnt);
        t_list_result r;
        r.status = st;
        r.index  = idx[IDX_W-1:0];
        r.data   = dat;
        r.count  = cnt[IDX_W-1:0];
        return r;
    endfunction

    // Lowest index holding val, or LIST_DEPTH when absent
    function automatic int first_hit(input logic signed [VAL_W-1:0] val);
        for (int k = 0; k < shadow_len; k++) begin
            if (shadow_entries[k] == val) return k;
        end
        return LIST_DEPTH;
    endfunction

    // Apply one command to the shadow list and work out its result
    task automatic predict_list_result(input logic [CMD_W-1:0] cmd,
                                       input logic signed [VAL_W-1:0] val,
                                       input logic signed [VAL_W-1:0] nval,
                                       input logic [POS_W-1:0] pos,
                                       output t_list_result res);
        int                      hit;
        int                      at;
        logic signed [VAL_W-1:0] top;
        res = make_result(STAT_OK, 0, '0, 0);
        at  = int'(pos);
        case (cmd) inside
            OP_APPEND: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                    res.index = shadow_len[IDX_W-1:0];
                end
            end
            OP_REPLACE, OP_DELETE, OP_FIND: begin
                hit = first_hit(val);
                if (hit >= LIST_DEPTH) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    res.index = hit[IDX_W-1:0];
                    if (cmd == OP_REPLACE) shadow_entries[hit] = nval;
                    if (cmd == OP_DELETE) begin
                        for (int k = hit; k + 1 < shadow_len; k++)
                            shadow_entries[k] = shadow_entries[k + 1];
                        shadow_len--;
                    end
                end
            end
            OP_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = STAT_FULL;
                end else if (at >= shadow_len) begin
                    res.status = STAT_BAD_POS;
                end else begin
                    for (int k = shadow_len; k > at; k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[at] = val;
                    shadow_len++;
                    res.index = IDX_W'(pos);
                end
            end
            OP_MAX: begin
                if (shadow_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    top = shadow_entries[0];
                    for (int k = 1; k < shadow_len; k++)
                        if (shadow_entries[k] > top) top = shadow_entries[k];
                    res.data = top;
                end
            end
            OP_READ: begin
                if (at >= shadow_len) begin
                    res.status = STAT_BAD_POS;
                end else begin
                    res.data  = shadow_entries[at];
                    res.index = IDX_W'(pos);
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_len[IDX_W-1:0];
    endtask

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Favor values already in the list so searches hit
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && shadow_len > 0) return shadow_entries[$urandom_range(0, shadow_len - 1)];
        if (r < 70) return $urandom_range(0, 7);
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 15) return POS_W'($urandom_range(0, 1023));
        if (shadow_len == 0 || r < 35) begin
            p = $urandom_range(0, shadow_len);
            return (p > 1023) ? 10'd1023 : p[POS_W-1:0];
        end
        return POS_W'($urandom_range(0, shadow_len - 1));
    endfunction

    // Present one item, hold it until taken, then queue its expected result
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                             input logic signed [VAL_W-1:0] nval, input logic [POS_W-1:0] pos,
                             input bit typed, input t_list_result typed_res);
        t_list_result res;
        int           gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command   <= cmd;
        i_value     <= val;
        i_new_value <= nval;
        i_position  <= pos;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_list_result(cmd, val, nval, pos, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic send_random_item(input int cap);
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] val;
        int                      r;
        r = $urandom_range(0, 99);
        if (r < 22)      cmd = OP_APPEND;
        else if (r < 34) cmd = OP_REPLACE;
        else if (r < 48) cmd = OP_DELETE;
        else if (r < 60) cmd = OP_FIND;
        else if (r < 74) cmd = OP_INSERT;
        else if (r < 82) cmd = OP_MAX;
        else if (r < 96) cmd = OP_READ;
        else             cmd = OP_UNUSED;
        val = pick_value();
        // Keep the list short: turn growth into a delete of a present value
        if ((cmd == OP_APPEND || cmd == OP_INSERT) && shadow_len >= cap && cap < LIST_DEPTH) begin
            cmd = OP_DELETE;
            val = shadow_entries[$urandom_range(0, shadow_len - 1)];
        end
        send_item(cmd, val, pick_value(), pick_position(), 1'b0, blank_res);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                           input logic signed [VAL_W-1:0] nval, input int pos, input bit typed,
                           input t_status st, input int idx,
                           input logic signed [VAL_W-1:0] dat, input int cnt);
        t_stim_row row;
        row.cmd   = cmd;
        row.val   = val;
        row.nval  = nval;
        row.pos   = pos[POS_W-1:0];
        row.typed = typed;
        row.res   = make_result(st, idx, dat, cnt);
        directed_rows.push_back(row);
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", VAL_W'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", VAL_W'(o_status), VAL_W'(want.status));
                if (o_index !== want.index)
                    report_mismatch("index", VAL_W'(o_index), VAL_W'(want.index));
                if (o_data !== want.data) report_mismatch("data", o_data, want.data);
                if (o_count !== want.count)
                    report_mismatch("count", VAL_W'(o_count), VAL_W'(want.count));
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("array_list_table_engine regression: fail");
            $finish;
        end
    end

    initial begin
        int cap;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every search, read, insert and max fails
        add_row(OP_MAX,     0,       0, 0,    1'b1, STAT_EMPTY,     0, 0, 0);
        add_row(OP_FIND,    5,       0, 0,    1'b1, STAT_NOT_FOUND, 0, 0, 0);
        add_row(OP_REPLACE, 5,       9, 0,    1'b1, STAT_NOT_FOUND, 0, 0, 0);
        add_row(OP_DELETE,  5,       0, 0,    1'b1, STAT_NOT_FOUND, 0, 0, 0);
        add_row(OP_READ,    0,       0, 0,    1'b1, STAT_BAD_POS,   0, 0, 0);
        add_row(OP_INSERT,  7,       0, 0,    1'b1, STAT_BAD_POS,   0, 0, 0);
        add_row(OP_UNUSED,  VAL_MAX, VAL_MIN, 1023, 1'b1, STAT_OK,  0, 0, 0);
        // Fill with extremes and a duplicate, then check max, find, reads and bad positions
        add_row(OP_APPEND,  VAL_MAX, 0, 1023, 1'b1, STAT_OK, 1, 0, 1);
        add_row(OP_APPEND,  VAL_MIN, 0, 0,    1'b1, STAT_OK, 2, 0, 2);
        add_row(OP_APPEND,  -1,      0, 0,    1'b1, STAT_OK, 3, 0, 3);
        add_row(OP_APPEND,  VAL_MAX, 0, 0,    1'b1, STAT_OK, 4, 0, 4);
        add_row(OP_MAX,     0,       0, 0,    1'b1, STAT_OK, 0, VAL_MAX, 4);
        add_row(OP_FIND,    VAL_MAX, 0, 0,    1'b1, STAT_OK, 0, 0, 4);
        add_row(OP_READ,    0,       0, 1,    1'b1, STAT_OK, 1, VAL_MIN, 4);
        add_row(OP_READ,    0,       0, 4,    1'b1, STAT_BAD_POS, 0, 0, 4);
        add_row(OP_READ,    0,       0, 1023, 1'b1, STAT_BAD_POS, 0, 0, 4);
        add_row(OP_INSERT,  3,       0, 4,    1'b1, STAT_BAD_POS, 0, 0, 4);
        // Shifts up and down, first match only
        add_row(OP_INSERT,  0,       0, 0,    1'b1, STAT_OK, 0, 0, 5);
        add_row(OP_REPLACE, VAL_MAX, 32'sh1234_5678, 0, 1'b1, STAT_OK, 1, 0, 5);
        add_row(OP_DELETE,  VAL_MIN, 0, 0,    1'b1, STAT_OK, 2, 0, 4);
        add_row(OP_READ,    0,       0, 2,    1'b1, STAT_OK, 2, -1, 4);
        add_row(OP_DELETE,  VAL_MAX, 0, 0,    1'b1, STAT_OK, 3, 0, 3);
        add_row(OP_MAX,     0,       0, 0,    1'b1, STAT_OK, 0, 32'sh1234_5678, 3);
        add_row(OP_INSERT,  VAL_MIN, 0, 2,    1'b1, STAT_OK, 2, 0, 4);
        add_row(OP_READ,    0,       0, 3,    1'b1, STAT_OK, 3, -1, 4);

        for (int k = 0; k < directed_rows.size(); k++) begin
            send_item(directed_rows[k].cmd, directed_rows[k].val, directed_rows[k].nval,
                      directed_rows[k].pos, directed_rows[k].typed, directed_rows[k].res);
        end

        // Short lists, length bound changed now and then
        cap = 4;
        for (int k = 0; k < 430; k++) begin
            if (k % 50 == 0) cap = $urandom_range(4, 48);
            send_random_item(cap);
        end

        // Grow a longer list, then work on it with longer walks
        while (shadow_len < LONG_LEN)
            send_item(OP_APPEND, pick_value(), pick_value(), pick_position(), 1'b0, blank_res);
        for (int k = 0; k < 50; k++) send_random_item(LIST_DEPTH);
        start <= 1'b0;

        // Drain, then allow a stray result to show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("array_list_table_engine regression: pass");
        end else begin
            $display("array_list_table_engine regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/alte_pkg.sv
hw/rtl/alte_ctrl.sv
hw/rtl/alte_dp.sv
hw/rtl/array_list_table_engine.sv
dv/array_list_table_engine_tb.sv
